// ===== rtl/qbi_pkg.sv =====
`timescale 1ns / 1ps

package qbi_pkg;

  // default geometry: 16-bit signed coordinates, Q1.16 ratio
  localparam int unsigned COORD_BITS_DEFAULT = 16;
  localparam int unsigned FRAC_BITS_DEFAULT  = 16;

  // entries in the queue between the geometry front and the divider
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ===== rtl/qbi_fifo.sv =====
`timescale 1ns / 1ps

module qbi_fifo #(
  parameter int unsigned WIDTH = 4 * qbi_pkg::COORD_BITS_DEFAULT + 2,
  parameter int unsigned DEPTH = qbi_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/qbi_front.sv =====
`timescale 1ns / 1ps

module qbi_front #(
  parameter int unsigned COORD_BITS = qbi_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // request side
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] corner0_x,
  input  logic signed [COORD_BITS-1:0] corner0_y,
  input  logic signed [COORD_BITS-1:0] corner1_x,
  input  logic signed [COORD_BITS-1:0] corner1_y,
  input  logic signed [COORD_BITS-1:0] corner2_x,
  input  logic signed [COORD_BITS-1:0] corner2_y,
  input  logic signed [COORD_BITS-1:0] corner3_x,
  input  logic signed [COORD_BITS-1:0] corner3_y,
  input  logic                         is_second,
  // queue side: {overlap, union, degenerate}
  output logic                         q_push,
  output logic [4*COORD_BITS+1:0]      q_data,
  input  logic                         q_full
);

  localparam int unsigned C = COORD_BITS;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_BOX   = 3'd1;
  localparam logic [2:0] F_AREA  = 3'd2;
  localparam logic [2:0] F_SPLIT = 3'd3;
  localparam logic [2:0] F_UNION = 3'd4;
  localparam logic [2:0] F_PUSH  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // captured request
  logic signed [C-1:0] cx [4];
  logic signed [C-1:0] cy [4];
  logic                second;

  // box of the current quad
  logic signed [C-1:0] bminx, bmaxx, bminy, bmaxy;
  logic [C-1:0]        dx, dy;
  // overlap with the held box
  logic [C-1:0]        ow, oh;
  logic                ov;
  // held quad
  logic signed [C-1:0] hminx, hmaxx, hminy, hmaxy;
  logic [2*C-1:0]      held_area;
  // results of the compare path
  logic [2*C-1:0]      area;
  logic [2*C-1:0]      inter;
  logic [2*C:0]        uni;
  logic                degen;

  // shared multiplier
  logic [C-1:0]        mul_a, mul_b;
  logic [2*C-1:0]      prod;

  // combinational helpers
  logic signed [C-1:0] wminx, wmaxx, wminy, wmaxy;
  logic signed [C:0]   ddx, ddy;
  logic [C:0]          adx, ady;
  logic signed [C-1:0] xl, xr, yb, yt;
  logic signed [C:0]   owd, ohd;
  logic signed [2*C+1:0] uni_w;
  logic                  degen_w;

  assign full   = (state != F_IDLE);
  assign q_push = (state == F_PUSH);
  assign q_data = {inter, uni, degen};

  always_comb begin
    wminx = cx[0];
    wmaxx = cx[0];
    wminy = cy[0];
    wmaxy = cy[0];
    for (int i = 1; i < 4; i++) begin
      if (cx[i] < wminx) wminx = cx[i];
      if (cx[i] > wmaxx) wmaxx = cx[i];
      if (cy[i] < wminy) wminy = cy[i];
      if (cy[i] > wmaxy) wmaxy = cy[i];
    end
  end

  // side lengths from corner 0 to corner 2
  assign ddx = {cx[2][C-1], cx[2]} - {cx[0][C-1], cx[0]};
  assign ddy = {cy[2][C-1], cy[2]} - {cy[0][C-1], cy[0]};
  assign adx = ddx[C] ? (~ddx + 1'b1) : ddx;
  assign ady = ddy[C] ? (~ddy + 1'b1) : ddy;

  assign xl  = (hminx > bminx) ? hminx : bminx;
  assign xr  = (hmaxx < bmaxx) ? hmaxx : bmaxx;
  assign yb  = (hminy > bminy) ? hminy : bminy;
  assign yt  = (hmaxy < bmaxy) ? hmaxy : bmaxy;
  assign owd = {xr[C-1], xr} - {xl[C-1], xl};
  assign ohd = {yt[C-1], yt} - {yb[C-1], yb};

  // prod holds the overlap area while in F_UNION
  assign uni_w   = $signed({2'b00, held_area}) + $signed({2'b00, area})
                 - $signed({2'b00, prod});
  assign degen_w = uni_w[2*C+1] || (uni_w == '0);

  assign mul_a = (state == F_SPLIT) ? (ov ? ow : '0) : dx;
  assign mul_b = (state == F_SPLIT) ? (ov ? oh : '0) : dy;

  always_ff @(posedge clk) begin
    prod <= {{C{1'b0}}, mul_a} * {{C{1'b0}}, mul_b};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (push) state_next = F_BOX;
      F_BOX:   state_next = F_AREA;
      F_AREA:  state_next = F_SPLIT;
      F_SPLIT: state_next = second ? F_UNION : F_IDLE;
      F_UNION: state_next = F_PUSH;
      F_PUSH:  if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // held box and area
  always_ff @(posedge clk) begin
    if (rst) begin
      hminx     <= '0;
      hmaxx     <= '0;
      hminy     <= '0;
      hmaxy     <= '0;
      held_area <= '0;
    end else if (state == F_SPLIT && !second) begin
      hminx     <= bminx;
      hmaxx     <= bmaxx;
      hminy     <= bminy;
      hmaxy     <= bmaxy;
      held_area <= prod;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      cx[0]  <= corner0_x;
      cy[0]  <= corner0_y;
      cx[1]  <= corner1_x;
      cy[1]  <= corner1_y;
      cx[2]  <= corner2_x;
      cy[2]  <= corner2_y;
      cx[3]  <= corner3_x;
      cy[3]  <= corner3_y;
      second <= is_second;
    end
    if (state == F_BOX) begin
      bminx <= wminx;
      bmaxx <= wmaxx;
      bminy <= wminy;
      bmaxy <= wmaxy;
      dx    <= adx[C-1:0];
      dy    <= ady[C-1:0];
    end
    if (state == F_AREA) begin
      ow <= owd[C-1:0];
      oh <= ohd[C-1:0];
      ov <= (xr > xl) && (yt > yb);
    end
    if (state == F_SPLIT) begin
      area <= prod;
    end
    if (state == F_UNION) begin
      inter <= prod;
      degen <= degen_w;
      uni   <= degen_w ? '0 : uni_w[2*C:0];
    end
  end

endmodule

// ===== rtl/qbi_back.sv =====
`timescale 1ns / 1ps

module qbi_back #(
  parameter int unsigned COORD_BITS = qbi_pkg::COORD_BITS_DEFAULT,
  parameter int unsigned FRAC_BITS  = qbi_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // queue side
  input  logic                      q_empty,
  input  logic [4*COORD_BITS+1:0]   q_data,
  output logic                      q_pop,
  // result side
  output logic                      empty,
  input  logic                      pop,
  output logic [FRAC_BITS:0]        iou_ratio,
  output logic [2*COORD_BITS-1:0]   overlap_area,
  output logic [2*COORD_BITS:0]     union_area,
  output logic                      union_degenerate
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned CW = $clog2(F + 1);
  localparam logic [F:0]  ONE = {1'b1, {F{1'b0}}};

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_CHECK = 2'd1;
  localparam logic [1:0] B_DIV   = 2'd2;
  localparam logic [1:0] B_DONE  = 2'd3;

  logic [1:0]     state;
  logic [1:0]     state_next;
  logic [2*C-1:0] inter;
  logic [2*C:0]   uni;
  logic           degen;
  logic [2*C+1:0] rem;
  logic [F:0]     quo;
  logic           sat;
  logic [CW-1:0]  cnt;
  logic           out_valid;

  logic [2*C+1:0] inter_ext;
  logic [2*C+1:0] twice;
  logic           sat_w;
  logic [2*C+2:0] diff;
  logic           ge;
  logic [2*C+1:0] rem_sel;
  logic           load;
  logic [F:0]     ratio_w;

  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign empty     = !out_valid;

  assign inter_ext = {2'b00, inter};
  assign twice     = {uni, 1'b0};
  // a ratio of two or more cannot fit the quotient register
  assign sat_w     = !degen && (inter_ext >= twice);

  // one restoring step: compare, subtract, shift
  assign diff      = {1'b0, rem} - {2'b00, uni};
  assign ge        = !diff[2*C+2];
  assign rem_sel   = ge ? diff[2*C+1:0] : rem;

  assign load      = (state == B_DONE) && (!out_valid || pop);
  assign ratio_w   = degen ? '0 :
                     (sat || (quo[F] && (|quo[F-1:0]))) ? ONE : quo;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!q_empty) state_next = B_CHECK;
      B_CHECK: state_next = (degen || sat_w) ? B_DONE : B_DIV;
      B_DIV:   if (cnt == CW'(F)) state_next = B_DONE;
      B_DONE:  if (load) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      inter <= q_data[4*C+1 -: 2*C];
      uni   <= q_data[2*C+1:1];
      degen <= q_data[0];
    end
    if (state == B_CHECK) begin
      sat <= sat_w;
      quo <= '0;
      rem <= inter_ext;
      cnt <= '0;
    end
    if (state == B_DIV) begin
      quo <= {quo[F-1:0], ge};
      rem <= {rem_sel[2*C:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
    if (load) begin
      iou_ratio        <= ratio_w;
      overlap_area     <= inter;
      union_area       <= uni;
      union_degenerate <= degen;
    end
  end

endmodule

// ===== rtl/quad_bounding_box_iou.sv =====
`timescale 1ns / 1ps

// Channel   Handshake        Payload
// request   push / full      corner0_x .. corner3_y, is_second
// result    pop / empty      iou_ratio, overlap_area, union_area, union_degenerate
//
// A request passes the front's box, area and split states, and with is_second
// high also the union state and the hand-off to the queue; the one multiplier
// there is shared between the area and the overlap. The divider pops a new entry
// only once the last is through: pop, check, one restoring step per quotient
// bit and the hand-off to the result register, so at the default it sets the
// sustained rate of compare requests. A degenerate union, or an overlap of twice
// the union or more, skips the divide and goes straight to the hand-off.
// rst is synchronous and clears the held box and area to zero and empties
// everything. A result waiting on the ports does not stop new requests: the
// queue and the divider keep absorbing work until both are full.
module quad_bounding_box_iou #(
  parameter int unsigned COORD_BITS = qbi_pkg::COORD_BITS_DEFAULT,
  parameter int unsigned FRAC_BITS  = qbi_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] corner0_x,
  input  logic signed [COORD_BITS-1:0] corner0_y,
  input  logic signed [COORD_BITS-1:0] corner1_x,
  input  logic signed [COORD_BITS-1:0] corner1_y,
  input  logic signed [COORD_BITS-1:0] corner2_x,
  input  logic signed [COORD_BITS-1:0] corner2_y,
  input  logic signed [COORD_BITS-1:0] corner3_x,
  input  logic signed [COORD_BITS-1:0] corner3_y,
  input  logic                         is_second,
  output logic                         empty,
  input  logic                         pop,
  output logic [FRAC_BITS:0]           iou_ratio,
  output logic [2*COORD_BITS-1:0]      overlap_area,
  output logic [2*COORD_BITS:0]        union_area,
  output logic                         union_degenerate
);

  // queue entry: overlap area, clamped union, degenerate flag
  localparam int unsigned QW = 4 * COORD_BITS + 2;

  logic          fq_push;
  logic [QW-1:0] fq_wdata;
  logic          fq_full;
  logic          fq_pop;
  logic [QW-1:0] fq_rdata;
  logic          fq_empty;

  // front: bounding boxes, areas, overlap and union; holds the first quad
  qbi_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .corner0_x (corner0_x),
    .corner0_y (corner0_y),
    .corner1_x (corner1_x),
    .corner1_y (corner1_y),
    .corner2_x (corner2_x),
    .corner2_y (corner2_y),
    .corner3_x (corner3_x),
    .corner3_y (corner3_y),
    .is_second (is_second),
    .q_push    (fq_push),
    .q_data    (fq_wdata),
    .q_full    (fq_full)
  );

  // short queue so the front can take the next request during a divide
  qbi_fifo #(
    .WIDTH (QW),
    .DEPTH (qbi_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_data (fq_wdata),
    .full    (fq_full),
    .rd_en   (fq_pop),
    .rd_data (fq_rdata),
    .empty   (fq_empty)
  );

  // back: saturating fractional divide and the result register
  qbi_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (fq_empty),
    .q_data           (fq_rdata),
    .q_pop            (fq_pop),
    .empty            (empty),
    .pop              (pop),
    .iou_ratio        (iou_ratio),
    .overlap_area     (overlap_area),
    .union_area       (union_area),
    .union_degenerate (union_degenerate)
  );

endmodule

// ===== rtl/qbi_checker.sv =====
`timescale 1ns / 1ps

module qbi_checker #(
  parameter int unsigned COORD_BITS = qbi_pkg::COORD_BITS_DEFAULT,
  parameter int unsigned FRAC_BITS  = qbi_pkg::FRAC_BITS_DEFAULT
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [FRAC_BITS:0]        iou_ratio,
  input logic [2*COORD_BITS-1:0]   overlap_area,
  input logic [2*COORD_BITS:0]     union_area,
  input logic                      union_degenerate
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // reset leaves nothing pending and the request side open
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> empty && !full)
    else $error("queues not clear after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && union_degenerate |-> iou_ratio == '0 && union_area == '0)
    else $error("degenerate result carries a ratio or union");

  a_ratio_cap: assert property (@(posedge clk) disable iff (rst)
    !empty |-> iou_ratio <= ONE)
    else $error("ratio above one");

  // full scale exactly when the overlap reaches the union
  a_ratio_full: assert property (@(posedge clk) disable iff (rst)
    !empty && !union_degenerate |->
      union_area != '0 && ((iou_ratio == ONE) == (overlap_area >= union_area)))
    else $error("ratio saturation disagrees with areas");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(iou_ratio) && $stable(overlap_area))
    else $error("waiting result changed");

endmodule

bind quad_bounding_box_iou qbi_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_qbi_checker (
  .clk              (clk),
  .rst              (rst),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .iou_ratio        (iou_ratio),
  .overlap_area     (overlap_area),
  .union_area       (union_area),
  .union_degenerate (union_degenerate)
);
